// ===== src/scf_pkg.sv =====
`timescale 1ns / 1ps

package scf_pkg;

    typedef enum logic [1:0] {
        KIND_CMD    = 2'd0,
        KIND_DATA7  = 2'd1,
        KIND_DATA14 = 2'd2,
        KIND_EOF    = 2'd3
    } kind_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CRC_ENABLE      = 3'd0,
        REG_DEVICE_NUMBER   = 3'd1,
        REG_COMPACT_NUMBER  = 3'd2,
        REG_HEADER_BYTE     = 3'd3,
        REG_CRC_POLYNOMIAL  = 3'd4
    } reg_index_t;

    localparam logic [7:0] MASK7 = 8'h7F;

    localparam logic       RST_CRC_ENABLE     = 1'b0;
    localparam logic [6:0] RST_DEVICE_NUMBER  = 7'd12;
    localparam logic [6:0] RST_COMPACT_NUMBER = 7'd12;
    localparam logic [7:0] RST_HEADER_BYTE    = 8'hAA;
    localparam logic [7:0] RST_CRC_POLYNOMIAL = 8'h91;

    typedef struct packed {
        logic       crc_enable;
        logic [6:0] device_number;
        logic [6:0] compact_device_number;
        logic [7:0] header_byte;
        logic [7:0] crc_polynomial;
    } cfg_t;

    typedef struct packed {
        logic       busy;
        logic [1:0] byte_idx;
    } status_t;

    // reflected CRC update over one byte
    function automatic logic [7:0] crc7_fold(
        input logic [7:0] crc,
        input logic [7:0] data,
        input logic [7:0] poly
    );
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[0])
            begin
                c = c ^ poly;
            end
            c = c >> 1;
        end
        return c;
    endfunction

endpackage

// ===== src/scf_ifs.sv =====
`timescale 1ns / 1ps

interface scf_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [13:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface scf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_of_item;

    modport source (output valid, output tx_byte, output last_of_item, input ready);
    modport sink   (input valid, input tx_byte, input last_of_item, output ready);
endinterface

// ===== src/servo_command_framer_crc7.sv =====
`timescale 1ns / 1ps
// An item is first held in the item registers; its first byte goes on to the output
// register once the output slot is free. Throughput: one byte per cycle on the output
// unless stalled; bytes: addressed command 3, 14-bit datum 2, EOF without CRC 0, others 1.
// The byte counter of the frame unit sets the rate; the next item is taken on the last byte.
// Reset: rst_n async low; clears CRC, control state and loads config defaults.

module servo_command_framer_crc7 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [scf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [scf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    scf_item_if.sink                         item,
    scf_byte_if.source                       tx
);

    scf_pkg::cfg_t    cfg;
    scf_pkg::status_t status;

    scf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    scf_frame_unit u_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .tx     (tx),
        .status (status)
    );

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        status.byte_idx != 2'd3)
        else $error("byte index out of range");

    a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
        !status.busy |-> status.byte_idx == 2'd0)
        else $error("byte index nonzero while idle");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        status.busy && !item.ready |=> status.busy)
        else $error("item dropped before its bytes were sent");

    a_stall_no_adv: assert property (@(posedge clk) disable iff (!rst_n)
        tx.valid && !tx.ready |=> status.byte_idx == $past(status.byte_idx))
        else $error("byte index advanced while output stalled");

endmodule

// ===== src/scf_cfg_regs.sv =====
`timescale 1ns / 1ps

module scf_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [scf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [scf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output scf_pkg::cfg_t                    cfg
);

    scf_pkg::cfg_t cfg_reg;
    scf_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                scf_pkg::REG_CRC_ENABLE:     cfg_next.crc_enable            = cfg_wdata[0];
                scf_pkg::REG_DEVICE_NUMBER:  cfg_next.device_number         = cfg_wdata[6:0];
                scf_pkg::REG_COMPACT_NUMBER: cfg_next.compact_device_number = cfg_wdata[6:0];
                scf_pkg::REG_HEADER_BYTE:    cfg_next.header_byte           = cfg_wdata;
                scf_pkg::REG_CRC_POLYNOMIAL: cfg_next.crc_polynomial        = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.crc_enable            <= scf_pkg::RST_CRC_ENABLE;
            cfg_reg.device_number         <= scf_pkg::RST_DEVICE_NUMBER;
            cfg_reg.compact_device_number <= scf_pkg::RST_COMPACT_NUMBER;
            cfg_reg.header_byte           <= scf_pkg::RST_HEADER_BYTE;
            cfg_reg.crc_polynomial        <= scf_pkg::RST_CRC_POLYNOMIAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/scf_frame_unit.sv =====
`timescale 1ns / 1ps

module scf_frame_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  scf_pkg::cfg_t     cfg,
    scf_item_if.sink          item,
    scf_byte_if.source        tx,
    output scf_pkg::status_t  status
);

    logic                 item_valid_reg;
    logic                 item_valid_next;
    scf_pkg::kind_t       kind_reg;
    logic [13:0]          value_reg;
    logic [1:0]           idx_reg;
    logic [1:0]           idx_next;
    logic [7:0]           crc_reg;
    logic [7:0]           crc_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 out_last_reg;

    logic                 addressed;
    logic [1:0]           count;
    logic                 is_last;
    logic [7:0]           cur_byte;
    logic                 slot_free;
    logic                 adv;
    logic                 done;
    logic                 load;

    assign addressed = cfg.device_number != cfg.compact_device_number;

    always_comb
    begin
        count    = 2'd0;
        cur_byte = 8'h00;
        case (kind_reg)
            scf_pkg::KIND_CMD:
            begin
                count = addressed ? 2'd3 : 2'd1;
                if (!addressed)
                begin
                    cur_byte = value_reg[7:0];
                end
                else
                begin
                    case (idx_reg)
                        2'd0:    cur_byte = cfg.header_byte;
                        2'd1:    cur_byte = {1'b0, cfg.device_number};
                        default: cur_byte = value_reg[7:0] & scf_pkg::MASK7;
                    endcase
                end
            end
            scf_pkg::KIND_DATA7:
            begin
                count    = 2'd1;
                cur_byte = value_reg[7:0] & scf_pkg::MASK7;
            end
            scf_pkg::KIND_DATA14:
            begin
                count    = 2'd2;
                cur_byte = (idx_reg == 2'd0) ? (value_reg[7:0] & scf_pkg::MASK7)
                                             : {1'b0, value_reg[13:7]};
            end
            default:
            begin
                count    = cfg.crc_enable ? 2'd1 : 2'd0;
                cur_byte = crc_reg;
            end
        endcase
    end

    assign is_last   = idx_reg == (count - 2'd1);
    assign slot_free = !out_valid_reg || tx.ready;
    assign adv       = item_valid_reg && (count != 2'd0) && slot_free;
    assign done      = item_valid_reg && ((count == 2'd0) || (adv && is_last));
    assign item.ready = !item_valid_reg || done;
    assign load      = item.valid && item.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (load)
        begin
            item_valid_next = 1'b1;
        end
        else if (done)
        begin
            item_valid_next = 1'b0;
        end

        idx_next = idx_reg;
        if (done)
        begin
            idx_next = 2'd0;
        end
        else if (adv)
        begin
            idx_next = idx_reg + 2'd1;
        end

        // check byte itself is not folded; end of frame clears it when CRC is on
        crc_next = crc_reg;
        if (adv && cfg.crc_enable)
        begin
            if (kind_reg == scf_pkg::KIND_EOF)
            begin
                crc_next = 8'h00;
            end
            else
            begin
                crc_next = scf_pkg::crc7_fold(crc_reg, cur_byte, cfg.crc_polynomial);
            end
        end

        out_valid_next = out_valid_reg;
        if (slot_free)
        begin
            out_valid_next = adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
            crc_reg        <= 8'h00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            idx_reg        <= idx_next;
            crc_reg        <= crc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= scf_pkg::kind_t'(item.kind);
            value_reg <= item.value;
        end
        if (adv)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= is_last;
        end
    end

    assign tx.valid        = out_valid_reg;
    assign tx.tx_byte      = out_byte_reg;
    assign tx.last_of_item = out_last_reg;

    assign status.busy     = item_valid_reg;
    assign status.byte_idx = idx_reg;

endmodule

// ===== sim/tb_servo_command_framer_crc7.sv =====
`timescale 1ns / 1ps

module tb_servo_command_framer_crc7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 50;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_of_item;
    } tx_exp_t;

    typedef struct {
        bit                               is_cfg;
        logic [scf_pkg::CFG_INDEX_W-1:0]  reg_idx;
        logic [scf_pkg::CFG_DATA_W-1:0]   reg_data;
        scf_pkg::kind_t                   kind;
        logic [13:0]                      value;
        int                               n_typed;
        logic [2:0][7:0]                  typed;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [scf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [scf_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    scf_item_if item_ch ();
    scf_byte_if byte_ch ();

    servo_command_framer_crc7 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .tx        (byte_ch)
    );

    // shadow of the block's registers and CRC
    logic       m_crc_en;
    logic [6:0] m_dev;
    logic [6:0] m_compact;
    logic [7:0] m_header;
    logic [7:0] m_poly;
    logic [7:0] crc_acc;

    tx_exp_t   pending_tx [$];
    plan_row_t plan [$];

    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    bit hold_req = 1'b0;
    int mismatch_count = 0;
    int cycle_count = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] crc7_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        repeat (8)
        begin
            r = r[0] ? ((r ^ m_poly) >> 1) : (r >> 1);
        end
        return r;
    endfunction

    function automatic void frame_item(input scf_pkg::kind_t k, input logic [13:0] v,
                                       output logic [2:0][7:0] b, output int n);
        int i;
        n = 0;
        b = '0;
        case (k)
            scf_pkg::KIND_CMD:
            begin
                if (m_dev != m_compact)
                begin
                    b[0] = m_header;
                    b[1] = {1'b0, m_dev};
                    b[2] = {1'b0, v[6:0]};
                    n = 3;
                end
                else
                begin
                    b[0] = v[7:0];
                    n = 1;
                end
            end
            scf_pkg::KIND_DATA7:
            begin
                b[0] = {1'b0, v[6:0]};
                n = 1;
            end
            scf_pkg::KIND_DATA14:
            begin
                b[0] = {1'b0, v[6:0]};
                b[1] = {1'b0, v[13:7]};
                n = 2;
            end
            default:
            begin
                if (m_crc_en)
                begin
                    b[0] = crc_acc;
                    crc_acc = '0;
                    n = 1;
                end
            end
        endcase
        if (m_crc_en && k != scf_pkg::KIND_EOF)
        begin
            for (i = 0; i < n; i++)
            begin
                crc_acc = crc7_step(crc_acc, b[i]);
            end
        end
    endfunction

    function automatic logic [13:0] draw_value();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(0, 1) ? 14'h3FFF : 14'h0000;
        end
        return 14'($urandom_range(0, 16383));
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("mismatch on %s: expected %02h, got %02h", what, want, got);
        end
    endtask

    task automatic add_item(input scf_pkg::kind_t k, input logic [13:0] v, input int n,
                            input logic [7:0] b0, input logic [7:0] b1,
                            input logic [7:0] b2);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.reg_idx = '0;
        row.reg_data = '0;
        row.kind = k;
        row.value = v;
        row.n_typed = n;
        row.typed[0] = b0;
        row.typed[1] = b1;
        row.typed[2] = b2;
        plan.push_back(row);
    endtask

    task automatic add_cfg(input logic [scf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [scf_pkg::CFG_DATA_W-1:0] data);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_data = data;
        row.kind = scf_pkg::KIND_CMD;
        row.value = '0;
        row.n_typed = 0;
        row.typed = '0;
        plan.push_back(row);
    endtask

    // leaves cfg_we high; the caller lowers it after the last write of a batch
    task automatic write_reg(input logic [scf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [scf_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            scf_pkg::REG_CRC_ENABLE:     m_crc_en = data[0];
            scf_pkg::REG_DEVICE_NUMBER:  m_dev = data[6:0];
            scf_pkg::REG_COMPACT_NUMBER: m_compact = data[6:0];
            scf_pkg::REG_HEADER_BYTE:    m_header = data;
            scf_pkg::REG_CRC_POLYNOMIAL: m_poly = data;
            default: ;
        endcase
    endtask

    // returns at the transfer edge with valid still high
    task automatic send_item(input scf_pkg::kind_t k, input logic [13:0] v,
                             input int n_typed, input logic [2:0][7:0] typed);
        int gap;
        int n;
        int i;
        logic [2:0][7:0] b;
        tx_exp_t e;
        gap = src_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind <= k;
        item_ch.value <= v;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        frame_item(k, v, b, n);
        if (n_typed >= 0)
        begin
            b = typed;
            n = n_typed;
        end
        for (i = 0; i < n; i++)
        begin
            e.tx_byte = b[i];
            e.last_of_item = (i == n - 1);
            pending_tx.push_back(e);
        end
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (pending_tx.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_tx
        tx_exp_t head;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (pending_tx.size() == 0)
            begin
                report_mismatch("byte with nothing pending", 8'hxx, byte_ch.tx_byte);
            end
            else
            begin
                head = pending_tx.pop_front();
                if (byte_ch.tx_byte !== head.tx_byte)
                begin
                    report_mismatch("tx_byte", head.tx_byte, byte_ch.tx_byte);
                end
                if (byte_ch.last_of_item !== head.last_of_item)
                begin
                    report_mismatch("last_of_item", {7'b0, head.last_of_item},
                                    {7'b0, byte_ch.last_of_item});
                end
            end
        end
    end

    // receiver: random wait before each transfer when sink_idle is set, one long hold-off on request
    initial
    begin : tx_sink
        int gap;
        byte_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            else
            begin
                gap = sink_idle ? $urandom_range(0, 7) : 0;
            end
            if (gap > 0)
            begin
                byte_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_ch.ready <= 1'b1;
            @(posedge clk);
            while (!byte_ch.valid) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        bit prev_cfg;
        int phase;
        int r;
        int nd;
        int sent;
        logic [7:0] d;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= scf_pkg::REG_CRC_ENABLE;
        cfg_wdata <= '0;
        item_ch.valid <= 1'b0;
        item_ch.kind <= scf_pkg::KIND_CMD;
        item_ch.value <= '0;
        m_crc_en = scf_pkg::RST_CRC_ENABLE;
        m_dev = scf_pkg::RST_DEVICE_NUMBER;
        m_compact = scf_pkg::RST_COMPACT_NUMBER;
        m_header = scf_pkg::RST_HEADER_BYTE;
        m_poly = scf_pkg::RST_CRC_POLYNOMIAL;
        crc_acc = '0;

        // defaults: compact mode, CRC off
        add_item(scf_pkg::KIND_CMD,    14'h0000, 1, 8'h00, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_CMD,    14'h3FFF, 1, 8'hFF, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_CMD,    14'h01A5, 1, 8'hA5, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_DATA7,  14'h3FFF, 1, 8'h7F, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_DATA7,  14'h0000, 1, 8'h00, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_DATA14, 14'h3FFF, 2, 8'h7F, 8'h7F, 8'h00);
        add_item(scf_pkg::KIND_DATA14, 14'h0080, 2, 8'h00, 8'h01, 8'h00);
        add_item(scf_pkg::KIND_EOF,    14'h3FFF, 0, 8'h00, 8'h00, 8'h00);
        // writes past the register list are dropped
        add_cfg(3'd5, 8'hFF);
        add_cfg(3'd7, 8'h00);
        add_item(scf_pkg::KIND_CMD,    14'h00C3, 1, 8'hC3, 8'h00, 8'h00);
        add_cfg(scf_pkg::REG_DEVICE_NUMBER, 8'hFF);
        add_item(scf_pkg::KIND_CMD,    14'h3FFF, 3, 8'hAA, 8'h7F, 8'h7F);
        add_item(scf_pkg::KIND_CMD,    14'h0080, 3, 8'hAA, 8'h7F, 8'h00);
        add_cfg(scf_pkg::REG_HEADER_BYTE, 8'h00);
        add_cfg(scf_pkg::REG_DEVICE_NUMBER, 8'h00);
        add_cfg(scf_pkg::REG_COMPACT_NUMBER, 8'hFF);
        add_item(scf_pkg::KIND_CMD,    14'h0055, 3, 8'h00, 8'h00, 8'h55);
        add_cfg(scf_pkg::REG_HEADER_BYTE, 8'hFF);
        add_item(scf_pkg::KIND_CMD,    14'h00FF, 3, 8'hFF, 8'h00, 8'h7F);
        add_cfg(scf_pkg::REG_CRC_ENABLE, 8'h01);
        add_item(scf_pkg::KIND_CMD,    14'h0012, -1, 8'h00, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_DATA14, 14'h2ABC, -1, 8'h00, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_EOF,    14'h0000, -1, 8'h00, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_EOF,    14'h0000, 1, 8'h00, 8'h00, 8'h00);
        // CRC switched off and back on mid-frame
        add_item(scf_pkg::KIND_DATA7,  14'h0033, -1, 8'h00, 8'h00, 8'h00);
        add_cfg(scf_pkg::REG_CRC_ENABLE, 8'hFE);
        add_item(scf_pkg::KIND_DATA7,  14'h0044, 1, 8'h44, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_EOF,    14'h0000, 0, 8'h00, 8'h00, 8'h00);
        add_cfg(scf_pkg::REG_CRC_ENABLE, 8'h01);
        add_item(scf_pkg::KIND_EOF,    14'h0000, -1, 8'h00, 8'h00, 8'h00);
        add_cfg(scf_pkg::REG_CRC_POLYNOMIAL, 8'h00);
        add_cfg(scf_pkg::REG_DEVICE_NUMBER, 8'h00);
        add_cfg(scf_pkg::REG_COMPACT_NUMBER, 8'h00);
        add_item(scf_pkg::KIND_CMD,    14'h00C3, -1, 8'h00, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_EOF,    14'h0000, -1, 8'h00, 8'h00, 8'h00);
        add_cfg(scf_pkg::REG_CRC_POLYNOMIAL, 8'hFF);
        add_item(scf_pkg::KIND_DATA14, 14'h1555, -1, 8'h00, 8'h00, 8'h00);
        add_item(scf_pkg::KIND_EOF,    14'h0000, -1, 8'h00, 8'h00, 8'h00);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_cfg = 1'b0;
        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                if (!prev_cfg)
                begin
                    wait_idle();
                end
                write_reg(plan[i].reg_idx, plan[i].reg_data);
                prev_cfg = 1'b1;
            end
            else
            begin
                if (prev_cfg)
                begin
                    cfg_we <= 1'b0;
                end
                prev_cfg = 1'b0;
                send_item(plan[i].kind, plan[i].value, plan[i].n_typed, plan[i].typed);
            end
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            for (r = 0; r < 5; r++)
            begin
                case (phase)
                    0: d = 8'hFF;
                    1: d = 8'h00;
                    default: d = 8'($urandom_range(0, 255));
                endcase
                if (phase > 1 && r == scf_pkg::REG_CRC_ENABLE)
                begin
                    d[0] = ($urandom_range(0, 3) != 0);
                end
                if (phase > 1 && r == scf_pkg::REG_COMPACT_NUMBER && $urandom_range(0, 1))
                begin
                    d = {1'b0, m_dev};
                end
                write_reg(r[scf_pkg::CFG_INDEX_W-1:0], d);
            end
            if ($urandom_range(0, 1))
            begin
                write_reg(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)));
            end
            cfg_we <= 1'b0;

            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            if (phase == 2)
            begin
                hold_req = 1'b1;
                src_idle = 1'b0;
            end
            if (phase == 4)
            begin
                src_idle = 1'b0;
                sink_idle = 1'b0;
            end

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 6) != 0)
                begin
                    send_item(scf_pkg::KIND_CMD, draw_value(), -1, '0);
                    nd = $urandom_range(0, 3);
                    repeat (nd)
                    begin
                        send_item($urandom_range(0, 1) ? scf_pkg::KIND_DATA7
                                                       : scf_pkg::KIND_DATA14,
                                  draw_value(), -1, '0);
                    end
                    send_item(scf_pkg::KIND_EOF, draw_value(), -1, '0);
                    sent += nd + 2;
                end
                else
                begin
                    send_item(scf_pkg::kind_t'($urandom_range(0, 3)), draw_value(), -1, '0);
                    sent++;
                end
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/scf_pkg.sv
src/scf_ifs.sv
src/scf_cfg_regs.sv
src/scf_frame_unit.sv
src/servo_command_framer_crc7.sv
sim/tb_servo_command_framer_crc7.sv
